[rtl/rmv_pkg.sv]
// ----------------------------------------------------------------------------
// rmv_pkg
// Types and fixed widths shared by the per-arm running mean/variance core.
// ----------------------------------------------------------------------------
package rmv_pkg;

    localparam int ARM_BITS       = 6;
    localparam int SAMPLE_BITS    = 16;
    localparam int COUNT_BITS     = 20;
    localparam int VAR_BITS       = 31;
    localparam int TOTAL_BITS     = 26;
    localparam int STATUS_BITS    = 2;
    localparam int CFG_INDEX_BITS = 1;
    localparam int CFG_DATA_BITS  = 64;

    // Mean quotient carries extra fraction bits so that it always fits 31 bits.
    localparam int MEAN_EXTRA = 31 - SAMPLE_BITS;
    localparam int Q_BITS     = 31;
    localparam int SUM_BITS   = SAMPLE_BITS + COUNT_BITS;
    localparam int MAG_BITS   = SUM_BITS - 1;
    localparam int SQ_RAW     = 2 * SAMPLE_BITS - 1 + COUNT_BITS;
    localparam int SQ_BITS    = (SQ_RAW > 63) ? 63 : SQ_RAW;
    localparam int MSQ_BITS   = 2 * Q_BITS - 2 * MEAN_EXTRA;
    localparam int VARD_BITS  = SQ_BITS + 2;

    localparam logic [STATUS_BITS-1:0] ST_UPDATED = 2'd0;
    localparam logic [STATUS_BITS-1:0] ST_DROPPED = 2'd1;
    localparam logic [STATUS_BITS-1:0] ST_FULL    = 2'd2;

    localparam logic [CFG_INDEX_BITS-1:0] CFG_EXCLUDED_MASK = 1'b0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_MIN_VARIANCE  = 1'b1;

    typedef struct packed {
        logic [ARM_BITS-1:0]           arm_index;
        logic signed [SAMPLE_BITS-1:0] sample_value;
    } sample_t;

    typedef struct packed {
        logic [ARM_BITS-1:0]           arm_echo;
        logic [STATUS_BITS-1:0]        status;
        logic signed [SAMPLE_BITS-1:0] arm_mean;
        logic [VAR_BITS-1:0]           arm_variance;
        logic [COUNT_BITS-1:0]         arm_count;
        logic [TOTAL_BITS-1:0]         total_received;
    } result_t;

    typedef struct packed {
        logic signed [SUM_BITS-1:0]    sum;
        logic [SQ_BITS-1:0]            sumsq;
        logic [COUNT_BITS-1:0]         count;
        logic signed [SAMPLE_BITS-1:0] mean;
        logic [VAR_BITS-1:0]           variance;
    } entry_t;

endpackage

[rtl/rmv_ram.sv]
// ----------------------------------------------------------------------------
// rmv_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module rmv_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                             clk,
    input  logic                             we,
    input  logic [$clog2(DEPTH)-1:0]         waddr,
    input  logic [WIDTH-1:0]                 wdata,
    input  logic [$clog2(DEPTH)-1:0]         raddr,
    output logic [WIDTH-1:0]                 rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

[rtl/rmv_serdiv.sv]
// ----------------------------------------------------------------------------
// rmv_serdiv
// Restoring divider, one quotient bit per cycle. The caller guarantees that
// the quotient fits QUO_BITS, so the remainder starts from the dividend bits
// above the quotient.
// ----------------------------------------------------------------------------
module rmv_serdiv #(
    parameter int DIVIDEND_BITS = 8,
    parameter int QUO_BITS      = 8,
    parameter int DIVISOR_BITS  = 8
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    input  logic [DIVIDEND_BITS-1:0] dividend,
    input  logic [DIVISOR_BITS-1:0]  divisor,
    output logic                     busy,
    output logic [QUO_BITS-1:0]      quotient
);

    localparam int EXT_BITS  = DIVIDEND_BITS + DIVISOR_BITS;
    localparam int STEP_BITS = $clog2(QUO_BITS + 1);

    logic [STEP_BITS-1:0]    step_reg;
    logic [DIVISOR_BITS-1:0] rem_reg;
    logic [QUO_BITS-1:0]     shift_reg;
    logic [DIVISOR_BITS-1:0] divisor_reg;

    logic [EXT_BITS-1:0]     ext;
    logic [DIVISOR_BITS:0]   trial;
    logic [DIVISOR_BITS:0]   diff;
    logic                    fits;

    assign ext      = EXT_BITS'(dividend);
    assign trial    = {rem_reg, shift_reg[QUO_BITS-1]};
    assign fits     = trial >= {1'b0, divisor_reg};
    assign diff     = trial - {1'b0, divisor_reg};
    assign busy     = step_reg != '0;
    assign quotient = shift_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= '0;
        end
        else if (start)
        begin
            step_reg <= STEP_BITS'(QUO_BITS);
        end
        else if (busy)
        begin
            step_reg <= step_reg - 1'b1;
        end
    end

    // Quotient bits shift in from the bottom as dividend bits leave the top.
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg     <= ext[QUO_BITS +: DIVISOR_BITS];
            shift_reg   <= dividend[QUO_BITS-1:0];
            divisor_reg <= divisor;
        end
        else if (busy)
        begin
            rem_reg   <= fits ? diff[DIVISOR_BITS-1:0] : trial[DIVISOR_BITS-1:0];
            shift_reg <= {shift_reg[QUO_BITS-2:0], fits};
        end
    end

endmodule

[rtl/per_arm_running_mean_variance_core.sv]
// ----------------------------------------------------------------------------
// per_arm_running_mean_variance_core
// Per-arm sample count, running sum and sum of squares, with mean and
// floored variance recomputed on every accepted sample.
// ----------------------------------------------------------------------------
//  channel   handshake              payload
//  sample    sample_valid/stall     sample   (arm_index, sample_value)
//  result    result_valid/stall     result   (arm_echo .. total_received)
//  cfg       cfg_valid/cfg_ready    cfg_index, cfg_data
//
//  An updating sample runs a 31-step mean divider, then a 31-step shift-add
//  squarer, with the sum-of-squares divider running alongside. A dropped or
//  refused sample skips them; one sample is in work at a time.
//  rst_n clears all arm entries at once through per-arm valid bits.
//  result is held in an output register, so a stalled result frees the core
//  to take the next sample.
// ----------------------------------------------------------------------------
module per_arm_running_mean_variance_core
    import rmv_pkg::*;
#(
    parameter int MAX_ARMS = 64
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      sample_valid,
    output logic                      sample_stall,
    input  sample_t                   sample,
    output logic                      result_valid,
    input  logic                      result_stall,
    output result_t                   result,
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [CFG_DATA_BITS-1:0]  cfg_data
);

    localparam int AW         = $clog2(MAX_ARMS);
    localparam int ENTRY_BITS = $bits(entry_t);
    localparam int MUL_BITS   = $clog2(Q_BITS + 1);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_READ  = 4'd1;
    localparam logic [3:0] S_CHECK = 4'd2;
    localparam logic [3:0] S_ACCUM = 4'd3;
    localparam logic [3:0] S_START = 4'd4;
    localparam logic [3:0] S_QDIV  = 4'd5;
    localparam logic [3:0] S_MUL   = 4'd6;
    localparam logic [3:0] S_VAR   = 4'd7;
    localparam logic [3:0] S_FINAL = 4'd8;

    logic [3:0]                    state_reg;
    logic [3:0]                    state_next;
    logic [ARM_BITS-1:0]           arm_reg;
    logic signed [SAMPLE_BITS-1:0] sample_reg;
    logic [STATUS_BITS-1:0]        status_reg;
    entry_t                        entry_reg;
    logic [2*SAMPLE_BITS-1:0]      sq_reg;
    logic                          neg_reg;
    logic [2*Q_BITS-1:0]           prod_reg;
    logic [MUL_BITS-1:0]           mul_cnt_reg;
    logic signed [SAMPLE_BITS-1:0] mean_reg;
    logic signed [VARD_BITS-1:0]   vard_reg;
    logic [MAX_ARMS-1:0]           excl_reg;
    logic [VAR_BITS-1:0]           min_var_reg;
    logic [TOTAL_BITS-1:0]         total_reg;
    logic [MAX_ARMS-1:0]           valid_reg;
    result_t                       result_reg;
    logic                          result_valid_reg;

    logic                          accept;
    logic                          in_range;
    logic [AW-1:0]                 addr;
    logic [ENTRY_BITS-1:0]         ram_rdata;
    entry_t                        rd_entry;
    logic                          excluded;
    logic                          full;
    logic [SAMPLE_BITS-1:0]        mag_x;
    logic [2*SAMPLE_BITS-1:0]      sq_full;
    logic signed [SUM_BITS-1:0]    sum_new;
    logic [SQ_BITS:0]              sq_add;
    logic [SUM_BITS-1:0]           sum_abs;
    logic [MAG_BITS+MEAN_EXTRA-1:0] q_dividend;
    logic                          qdiv_busy;
    logic                          tdiv_busy;
    logic [Q_BITS-1:0]             q_val;
    logic [SQ_BITS-1:0]            term_val;
    logic                          start_div;
    logic [Q_BITS:0]               mul_sum;
    logic [MSQ_BITS-1:0]           msq;
    logic [SAMPLE_BITS-1:0]        coarse;
    logic signed [VARD_BITS-1:0]   min_ext;
    logic signed [VARD_BITS-1:0]   max_ext;
    logic [VAR_BITS-1:0]           var_floor;
    logic                          updated;
    logic                          out_free;
    logic                          finish;
    logic                          ram_we;
    entry_t                        wr_entry;
    logic [TOTAL_BITS-1:0]         total_new;
    result_t                       result_next;

    assign accept       = sample_valid && !sample_stall;
    assign sample_stall = state_reg != S_IDLE;
    assign cfg_ready    = 1'b1;
    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    assign in_range = {1'b0, sample.arm_index} < (ARM_BITS + 1)'(MAX_ARMS);
    assign addr     = arm_reg[AW-1:0];
    assign rd_entry = valid_reg[addr] ? entry_t'(ram_rdata) : '0;
    assign excluded = excl_reg[addr];
    assign full     = &rd_entry.count;

    assign mag_x   = sample_reg[SAMPLE_BITS-1] ? SAMPLE_BITS'(-sample_reg)
                                               : SAMPLE_BITS'(sample_reg);
    assign sq_full = {{SAMPLE_BITS{1'b0}}, mag_x} * {{SAMPLE_BITS{1'b0}}, mag_x};

    assign sum_new = entry_reg.sum + {{COUNT_BITS{sample_reg[SAMPLE_BITS-1]}}, sample_reg};
    assign sq_add  = {1'b0, entry_reg.sumsq} + (SQ_BITS + 1)'(sq_reg);

    assign sum_abs    = entry_reg.sum[SUM_BITS-1] ? SUM_BITS'(-entry_reg.sum)
                                                  : SUM_BITS'(entry_reg.sum);
    assign q_dividend = {sum_abs[MAG_BITS-1:0], {MEAN_EXTRA{1'b0}}};
    assign start_div  = state_reg == S_START;

    rmv_serdiv #(
        .DIVIDEND_BITS (MAG_BITS + MEAN_EXTRA),
        .QUO_BITS      (Q_BITS),
        .DIVISOR_BITS  (COUNT_BITS)
    ) u_mean_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start_div),
        .dividend (q_dividend),
        .divisor  (entry_reg.count),
        .busy     (qdiv_busy),
        .quotient (q_val)
    );

    rmv_serdiv #(
        .DIVIDEND_BITS (SQ_BITS),
        .QUO_BITS      (SQ_BITS),
        .DIVISOR_BITS  (COUNT_BITS)
    ) u_term_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start_div),
        .dividend (entry_reg.sumsq),
        .divisor  (entry_reg.count),
        .busy     (tdiv_busy),
        .quotient (term_val)
    );

    // Shift-add squarer: one multiplier bit per cycle.
    assign mul_sum = {1'b0, prod_reg[2*Q_BITS-1:Q_BITS]}
                   + (prod_reg[0] ? {1'b0, q_val} : {(Q_BITS + 1){1'b0}});
    assign msq     = prod_reg[2*Q_BITS-1:2*MEAN_EXTRA];
    assign coarse  = q_val[Q_BITS-1:MEAN_EXTRA];

    assign min_ext = VARD_BITS'(min_var_reg);
    assign max_ext = {{(VARD_BITS - VAR_BITS){1'b0}}, {VAR_BITS{1'b1}}};

    always_comb
    begin
        priority if (vard_reg < min_ext)
        begin
            var_floor = min_var_reg;
        end
        else if (vard_reg > max_ext)
        begin
            var_floor = {VAR_BITS{1'b1}};
        end
        else
        begin
            var_floor = vard_reg[VAR_BITS-1:0];
        end
    end

    assign updated   = status_reg == ST_UPDATED;
    assign out_free  = !result_valid_reg || !result_stall;
    assign finish    = (state_reg == S_FINAL) && out_free;
    assign ram_we    = finish && updated;
    assign total_new = (&total_reg) ? total_reg : total_reg + 1'b1;

    always_comb
    begin
        wr_entry          = entry_reg;
        wr_entry.mean     = mean_reg;
        wr_entry.variance = var_floor;
    end

    always_comb
    begin
        result_next.arm_echo       = arm_reg;
        result_next.status         = status_reg;
        result_next.arm_mean       = updated ? mean_reg : entry_reg.mean;
        result_next.arm_variance   = updated ? var_floor : entry_reg.variance;
        result_next.arm_count      = entry_reg.count;
        result_next.total_received = updated ? total_new : total_reg;
    end

    rmv_ram #(
        .WIDTH (ENTRY_BITS),
        .DEPTH (MAX_ARMS)
    ) u_arm_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (addr),
        .wdata (ENTRY_BITS'(wr_entry)),
        .raddr (addr),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = in_range ? S_READ : S_FINAL;
                end
            end
            S_READ:
            begin
                state_next = S_CHECK;
            end
            S_CHECK:
            begin
                state_next = (excluded || full) ? S_FINAL : S_ACCUM;
            end
            S_ACCUM:
            begin
                state_next = S_START;
            end
            S_START:
            begin
                state_next = S_QDIV;
            end
            S_QDIV:
            begin
                if (!qdiv_busy)
                begin
                    state_next = S_MUL;
                end
            end
            S_MUL:
            begin
                if (mul_cnt_reg == '0 && !tdiv_busy)
                begin
                    state_next = S_VAR;
                end
            end
            S_VAR:
            begin
                state_next = S_FINAL;
            end
            S_FINAL:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            result_valid_reg <= 1'b0;
            valid_reg        <= '0;
            total_reg        <= '0;
            excl_reg         <= '0;
            min_var_reg      <= VAR_BITS'(1);
            mul_cnt_reg      <= '0;
        end
        else
        begin
            state_reg <= state_next;

            if (finish)
            begin
                result_valid_reg <= 1'b1;
            end
            else if (!result_stall)
            begin
                result_valid_reg <= 1'b0;
            end

            if (ram_we)
            begin
                valid_reg[addr] <= 1'b1;
                total_reg       <= total_new;
            end

            if (state_reg == S_QDIV && !qdiv_busy)
            begin
                mul_cnt_reg <= MUL_BITS'(Q_BITS);
            end
            else if (mul_cnt_reg != '0)
            begin
                mul_cnt_reg <= mul_cnt_reg - 1'b1;
            end

            if (cfg_valid && cfg_ready)
            begin
                unique case (cfg_index)
                    CFG_EXCLUDED_MASK: excl_reg    <= cfg_data[MAX_ARMS-1:0];
                    CFG_MIN_VARIANCE:  min_var_reg <= cfg_data[VAR_BITS-1:0];
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            arm_reg    <= sample.arm_index;
            sample_reg <= sample.sample_value;
            if (!in_range)
            begin
                status_reg <= ST_DROPPED;
                entry_reg  <= '0;
            end
        end

        if (state_reg == S_CHECK)
        begin
            entry_reg <= rd_entry;
            sq_reg    <= sq_full;
            priority if (excluded)
            begin
                status_reg <= ST_DROPPED;
            end
            else if (full)
            begin
                status_reg <= ST_FULL;
            end
            else
            begin
                status_reg <= ST_UPDATED;
            end
        end

        if (state_reg == S_ACCUM)
        begin
            entry_reg.sum   <= sum_new;
            entry_reg.sumsq <= sq_add[SQ_BITS] ? {SQ_BITS{1'b1}} : sq_add[SQ_BITS-1:0];
            entry_reg.count <= entry_reg.count + 1'b1;
        end

        if (start_div)
        begin
            neg_reg <= entry_reg.sum[SUM_BITS-1];
        end

        // Load the multiplier, then shift right as partial products add in.
        if (state_reg == S_QDIV && !qdiv_busy)
        begin
            prod_reg <= {{Q_BITS{1'b0}}, q_val};
        end
        else if (mul_cnt_reg != '0)
        begin
            prod_reg <= {mul_sum, prod_reg[Q_BITS-1:1]};
        end

        if (state_reg == S_VAR)
        begin
            vard_reg <= VARD_BITS'(term_val) - VARD_BITS'(msq);
            mean_reg <= neg_reg ? SAMPLE_BITS'(-coarse) : SAMPLE_BITS'(coarse);
        end

        if (finish)
        begin
            result_reg <= result_next;
        end
    end

`ifndef SYNTHESIS
    a_total_monotone: assert property (@(posedge clk) disable iff (!rst_n)
        1'b1 |=> total_reg >= $past(total_reg))
        else $error("accepted total went down");

    a_units_done: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_VAR |-> !qdiv_busy && !tdiv_busy && mul_cnt_reg == '0)
        else $error("variance formed before the serial units finished");

    a_floor_held: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_FINAL && updated |-> var_floor >= min_var_reg)
        else $error("variance below the configured floor");

    a_write_count: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> wr_entry.count != '0 && valid_reg == $past(valid_reg))
        else $error("arm entry written with a zero count");
`endif

endmodule

[tb/per_arm_running_mean_variance_core_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// per_arm_running_mean_variance_core_tb
// Self-checking bench for the per-arm mean/variance core. A queue of samples
// feeds a clocked driver; a clocked monitor checks every result against a
// running statistics model updated at each accepted sample transaction.
// Phases sweep the exclusion mask, the variance floor and the idle and stall patterns.
// ----------------------------------------------------------------------------
module per_arm_running_mean_variance_core_tb;

    import rmv_pkg::*;

    localparam int          ARM_COUNT  = 64;
    localparam logic [63:0] SQ_CAP     = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam longint      VAR_CAP    = 64'h7FFF_FFFF;
    localparam int          MAX_REPORT = 10;

    logic                      clk;
    logic                      rst_n        = 1'b0;
    logic                      sample_valid = 1'b0;
    logic                      sample_stall;
    sample_t                   sample       = '0;
    logic                      result_valid;
    logic                      result_stall = 1'b0;
    result_t                   result;
    logic                      cfg_valid    = 1'b0;
    logic                      cfg_ready;
    logic [CFG_INDEX_BITS-1:0] cfg_index    = '0;
    logic [CFG_DATA_BITS-1:0]  cfg_data     = '0;

    // statistics model of the core
    longint                    arm_sum    [ARM_COUNT];
    bit [63:0]                 arm_sq_sum [ARM_COUNT];
    bit [COUNT_BITS-1:0]       arm_cnt    [ARM_COUNT];
    bit signed [SAMPLE_BITS-1:0] arm_mean_q [ARM_COUNT];
    bit [VAR_BITS-1:0]         arm_var_q  [ARM_COUNT];
    bit [TOTAL_BITS-1:0]       total_q;
    bit [63:0]                 excl_q      = '0;
    bit [VAR_BITS-1:0]         var_floor_q = 31'd1;

    sample_t                   sample_queue[$];
    result_t                   expected_stats[$];

    int                        send_idle_pct  = 0;
    int                        recv_stall_pct = 0;
    int                        fault_count    = 0;

    logic [ARM_BITS-1:0]       hot_arms [4];
    logic signed [SAMPLE_BITS-1:0] arm_bias [ARM_COUNT];

    per_arm_running_mean_variance_core uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (sample_valid),
        .sample_stall (sample_stall),
        .sample       (sample),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #20_000_000;
        $display("per_arm_running_mean_variance_core regression: fail");
        $finish;
    end

    // Apply one sample to the arm statistics and return the result it yields.
    function automatic result_t update_arm_stats(sample_t s);
        result_t   r;
        int        a;
        longint    x;
        longint    var_s;
        logic [63:0] mag;
        logic [63:0] sq;
        logic [63:0] quo;
        logic [63:0] mean_mag;
        logic [63:0] msq;
        logic [63:0] term;
        a = s.arm_index;
        x = longint'($signed(s.sample_value));
        r.arm_echo = s.arm_index;
        if (excl_q[a])
            r.status = ST_DROPPED;
        else if (arm_cnt[a] == '1)
            r.status = ST_FULL;
        else
        begin
            r.status = ST_UPDATED;
            mag = (x < 0) ? -x : x;
            sq = mag * mag;
            arm_sum[a] += x;
            if (arm_sq_sum[a] > SQ_CAP - sq)
                arm_sq_sum[a] = SQ_CAP;
            else
                arm_sq_sum[a] += sq;
            arm_cnt[a] += 1'b1;
            // mean quotient keeps MEAN_EXTRA fraction bits, truncated
            mag = (arm_sum[a] < 0) ? -arm_sum[a] : arm_sum[a];
            quo = (mag << MEAN_EXTRA) / arm_cnt[a];
            mean_mag = quo >> MEAN_EXTRA;
            arm_mean_q[a] = (arm_sum[a] < 0) ? -mean_mag[SAMPLE_BITS-1:0]
                                             : mean_mag[SAMPLE_BITS-1:0];
            msq = (quo * quo) >> (2 * MEAN_EXTRA);
            term = arm_sq_sum[a] / arm_cnt[a];
            var_s = longint'(term) - longint'(msq);
            if (var_s < longint'(var_floor_q))
                var_s = longint'(var_floor_q);
            if (var_s > VAR_CAP)
                var_s = VAR_CAP;
            arm_var_q[a] = var_s[VAR_BITS-1:0];
            if (total_q != '1)
                total_q += 1'b1;
        end
        r.arm_mean       = arm_mean_q[a];
        r.arm_variance   = arm_var_q[a];
        r.arm_count      = arm_cnt[a];
        r.total_received = total_q;
        return r;
    endfunction

    function automatic sample_t random_sample();
        sample_t s;
        int      pick;
        pick = $urandom_range(0, 99);
        if (pick < 70)
            s.arm_index = hot_arms[$urandom_range(0, 3)];
        else
            s.arm_index = ARM_BITS'($urandom_range(0, ARM_COUNT - 1));
        pick = $urandom_range(0, 99);
        if (pick < 25)
            s.sample_value = SAMPLE_BITS'($urandom);
        else if (pick < 50)
            // near-constant samples drive the variance toward the floor
            s.sample_value = arm_bias[s.arm_index] + SAMPLE_BITS'($urandom_range(0, 3));
        else if (pick < 65)
        begin
            case ($urandom_range(0, 4))
                0:       s.sample_value = 16'sh8000;
                1:       s.sample_value = 16'sh7FFF;
                2:       s.sample_value = 16'sh0000;
                3:       s.sample_value = 16'shFFFF;
                default: s.sample_value = 16'sh0001;
            endcase
        end
        else
            s.sample_value = SAMPLE_BITS'(int'($urandom_range(0, 512)) - 256);
        return s;
    endfunction

    task automatic push_sample(input logic [ARM_BITS-1:0] a,
                               input logic [SAMPLE_BITS-1:0] v);
        sample_t s;
        s.arm_index    = a;
        s.sample_value = v;
        sample_queue.push_back(s);
    endtask

    task automatic cfg_write(input logic [CFG_INDEX_BITS-1:0] idx,
                             input logic [CFG_DATA_BITS-1:0] data);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        if (idx == CFG_EXCLUDED_MASK)
            excl_q = data;
        else
            var_floor_q = data[VAR_BITS-1:0];
    endtask

    // Hold until every queued sample has gone in and every result has come out.
    task automatic wait_quiet();
        @(posedge clk);
        while (sample_queue.size() != 0 || sample_valid || expected_stats.size() != 0)
            @(posedge clk);
    endtask

    // Sample driver: present queued transactions, idle at random.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sample_valid <= 1'b0;
        end
        else
        begin
            if (sample_valid && !sample_stall)
                expected_stats.push_back(update_arm_stats(sample));
            if (!sample_valid || !sample_stall)
            begin
                if (sample_queue.size() != 0 && $urandom_range(0, 99) >= send_idle_pct)
                begin
                    sample       <= sample_queue.pop_front();
                    sample_valid <= 1'b1;
                end
                else
                begin
                    sample_valid <= 1'b0;
                end
            end
        end
    end

    // Result monitor: stall at random, check each accepted transaction.
    always @(posedge clk or negedge rst_n)
    begin : watch
        result_t want;
        if (!rst_n)
        begin
            result_stall <= 1'b0;
        end
        else
        begin
            if (result_valid && !result_stall)
            begin
                if (expected_stats.size() == 0)
                begin
                    fault_count++;
                    if (fault_count <= MAX_REPORT)
                        $display("unexpected result: arm %0d status %0d", result.arm_echo,
                                 result.status);
                end
                else
                begin
                    want = expected_stats.pop_front();
                    if (result.arm_echo !== want.arm_echo || result.status !== want.status ||
                        result.arm_mean !== want.arm_mean ||
                        result.arm_variance !== want.arm_variance ||
                        result.arm_count !== want.arm_count ||
                        result.total_received !== want.total_received)
                    begin
                        fault_count++;
                        if (fault_count <= MAX_REPORT)
                            $display({"mismatch (expected/actual): arm %0d/%0d status %0d/%0d",
                                      " mean %0d/%0d var %0d/%0d count %0d/%0d total %0d/%0d"},
                                     want.arm_echo, result.arm_echo, want.status,
                                     result.status, want.arm_mean, result.arm_mean,
                                     want.arm_variance, result.arm_variance, want.arm_count,
                                     result.arm_count, want.total_received,
                                     result.total_received);
                    end
                end
            end
            result_stall <= ($urandom_range(0, 99) < recv_stall_pct);
        end
    end

    initial
    begin : stimulus
        logic [63:0] mask;
        logic [63:0] floor_val;
        int          target;
        int          useful;
        sample_t     s;
        for (int i = 0; i < ARM_COUNT; i++)
            arm_bias[i] = SAMPLE_BITS'($urandom);
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // reset configuration: extremes on arms 0 and 63, zero sample, tiny sample
        push_sample(6'd0, 16'h7FFF);
        push_sample(6'd0, 16'h7FFF);
        push_sample(6'd0, 16'h8000);
        push_sample(6'd0, 16'h8000);
        push_sample(6'd0, 16'h0000);
        push_sample(6'd63, 16'h8000);
        push_sample(6'd63, 16'h8000);
        push_sample(6'd63, 16'h8000);
        push_sample(6'd63, 16'h0001);
        push_sample(6'd63, 16'hFFFF);
        push_sample(6'd5, 16'h0000);
        push_sample(6'd1, 16'h0001);
        wait_quiet();

        // excluded arms with and without history, floor of 2^30
        cfg_write(CFG_EXCLUDED_MASK, 64'h8000_0000_0000_0080);
        cfg_write(CFG_MIN_VARIANCE, 64'd1073741824);
        push_sample(6'd63, 16'h1234);
        push_sample(6'd7, 16'h7FFF);
        push_sample(6'd5, 16'h0000);
        push_sample(6'd0, 16'h7FFF);
        push_sample(6'd1, 16'h8000);
        wait_quiet();

        // zero floor: exact zero variance passes through
        cfg_write(CFG_MIN_VARIANCE, 64'd0);
        push_sample(6'd5, 16'h0000);
        wait_quiet();

        for (int ph = 0; ph < 8; ph++)
        begin
            target = 275;
            case (ph)
                0:
                begin
                    mask      = 64'd0;
                    floor_val = 64'd1;
                end
                1:
                begin
                    mask      = '1;
                    floor_val = 64'd1073741824;
                    target    = 25;
                end
                2:
                begin
                    mask      = {$urandom, $urandom} & {$urandom, $urandom};
                    floor_val = 64'd0;
                end
                3:
                begin
                    mask      = {$urandom, $urandom};
                    floor_val = $urandom_range(0, 4096);
                end
                4:
                begin
                    mask      = 64'hAAAA_AAAA_AAAA_AAAA;
                    floor_val = $urandom_range(0, 1 << 30);
                end
                5:
                begin
                    mask      = 64'h5555_5555_5555_5555;
                    floor_val = 64'd1;
                end
                6:
                begin
                    mask      = 64'd0;
                    floor_val = 64'd0;
                end
                default:
                begin
                    mask      = {$urandom, $urandom} & {$urandom, $urandom};
                    floor_val = $urandom_range(0, 65536);
                end
            endcase
            case (ph % 4)
                0:
                begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 0;
                end
                1:
                begin
                    send_idle_pct  = 56;
                    recv_stall_pct = 0;
                end
                2:
                begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 56;
                end
                default:
                begin
                    send_idle_pct  = 22;
                    recv_stall_pct = 22;
                end
            endcase
            cfg_write(CFG_EXCLUDED_MASK, mask);
            cfg_write(CFG_MIN_VARIANCE, floor_val);
            hot_arms[0] = '0;
            for (int i = 1; i < 4; i++)
                hot_arms[i] = ARM_BITS'($urandom_range(0, ARM_COUNT - 1));
            useful = 0;
            while (useful < target)
            begin
                s = random_sample();
                sample_queue.push_back(s);
                useful++;
            end
            wait_quiet();
        end

        send_idle_pct  = 0;
        recv_stall_pct = 0;
        repeat (100) @(posedge clk);
        if (fault_count == 0 && expected_stats.size() == 0)
            $display("per_arm_running_mean_variance_core regression: pass");
        else
            $display("per_arm_running_mean_variance_core regression: fail");
        $finish;
    end

endmodule

[filelist.f]
rtl/rmv_pkg.sv
rtl/rmv_ram.sv
rtl/rmv_serdiv.sv
rtl/per_arm_running_mean_variance_core.sv
tb/per_arm_running_mean_variance_core_tb.sv
